FILE: sv/pirl_pkg.sv
// Package for the positional insert/remove list.
// Holds field widths, command and status codes, and the controller state type.
// Depends on nothing; every other file of the block imports it.
package pirl_pkg;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_DONE
  } pirl_state_t;

endpackage

FILE: sv/pirl_if.sv
// Channel interfaces for the positional insert/remove list.
// Carries valid/ready and the payload of the command and result channels.
// Depends on pirl_pkg for the field widths.
interface pirl_in_if;
  import pirl_pkg::*;

  logic               valid;
  logic               ready;
  logic               cmd;
  logic [VALUE_W-1:0] value;
  logic signed [POS_W-1:0] position;

  modport source (output valid, cmd, value, position, input ready);
  modport sink   (input valid, cmd, value, position, output ready);
endinterface

interface pirl_out_if;
  import pirl_pkg::*;

  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  removed_value;
  logic [STATUS_W-1:0] status;
  logic [LEN_W-1:0]    length;

  modport source (output valid, removed_value, status, length, input ready);
  modport sink   (input valid, removed_value, status, length, output ready);
endinterface

FILE: sv/positional_insert_remove_list.sv
// Positional insert/remove list: up to CAPACITY 64-bit values held in one RAM.
// An insert shifts each entry from the old end down to the position one place back and then
// writes the new value; a remove reads the removed element and moves each later entry one
// place forward; a rejected command goes straight to the result.
// One transaction is worked at a time: the next can be taken as soon as the result shows.
// Reset (synchronous, active low) empties the list; RAM contents are not cleared.
module positional_insert_remove_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  pirl_in_if.sink     in_ch,
  pirl_out_if.source  out_ch
);
  import pirl_pkg::*;

  // AW addresses one entry; CW holds a count from zero to CAPACITY.
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Element storage. Only entries below the current count are ever read for
  // data that matters, so the array needs no clearing after reset.
  logic [VALUE_W-1:0] mem [CAPACITY];
  logic [VALUE_W-1:0] rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // Controller registers.
  pirl_state_t         state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [VALUE_W-1:0]  value_r, value_nxt;
  logic                pend_r, pend_nxt;
  logic                pend_first_r, pend_first_nxt;
  logic [AW-1:0]       pend_addr_r, pend_addr_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [VALUE_W-1:0]  removed_r, removed_nxt;

  // Result register toward the output channel.
  logic                out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0]  out_removed_r, out_removed_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [LEN_W-1:0]    out_length_r, out_length_nxt;

  // Position clamp: negative means the front, at or past the limit means the
  // limit itself (the end for an insert, the last element for a remove).
  logic [CW-1:0]    clamp_limit;
  logic [CW-1:0]    clamp_pos;
  logic [POS_W-1:0] pos_mag;

  always_comb begin
    clamp_limit = (in_ch.cmd == CMD_INSERT) ? count_r : CW'(count_r - 1'b1);
    pos_mag     = {1'b0, in_ch.position[POS_W-2:0]};
    if (in_ch.position[POS_W-1]) begin
      clamp_pos = '0;
    end else if (pos_mag >= POS_W'(clamp_limit)) begin
      clamp_pos = clamp_limit;
    end else begin
      clamp_pos = CW'(pos_mag);
    end
  end

  // A transaction is taken whenever the controller is idle; a result still
  // waiting in the output register does not hold up the next command.
  assign in_ch.ready = (state_r == S_IDLE);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.removed_value = out_removed_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.length        = out_length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r         <= idx_nxt;
    pos_r         <= pos_nxt;
    value_r       <= value_nxt;
    pend_first_r  <= pend_first_nxt;
    pend_addr_r   <= pend_addr_nxt;
    status_r      <= status_nxt;
    removed_r     <= removed_nxt;
    out_removed_r <= out_removed_nxt;
    out_status_r  <= out_status_nxt;
    out_length_r  <= out_length_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    count_nxt       = count_r;
    idx_nxt         = idx_r;
    pos_nxt         = pos_r;
    value_nxt       = value_r;
    pend_nxt        = pend_r;
    pend_first_nxt  = pend_first_r;
    pend_addr_nxt   = pend_addr_r;
    status_nxt      = status_r;
    removed_nxt     = removed_r;
    out_valid_nxt   = out_valid_r;
    out_removed_nxt = out_removed_r;
    out_status_nxt  = out_status_r;
    out_length_nxt  = out_length_r;
    mem_we          = 1'b0;
    mem_waddr       = pend_addr_r;
    mem_wdata       = rd_data_r;
    mem_raddr       = idx_r[AW-1:0];

    // The output register empties when the sink takes the transaction.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          value_nxt   = in_ch.value;
          pos_nxt     = clamp_pos;
          removed_nxt = '0;
          status_nxt  = ST_DONE;
          pend_nxt    = 1'b0;
          if (in_ch.cmd == CMD_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              status_nxt = ST_FULL;
              state_nxt  = S_DONE;
            end else begin
              // Shift runs from the old end down toward the insert position.
              idx_nxt   = count_r;
              count_nxt = CW'(count_r + 1'b1);
              state_nxt = S_INS;
            end
          end else begin
            if (count_r == '0) begin
              status_nxt = ST_EMPTY;
              state_nxt  = S_DONE;
            end else begin
              // Reads run from the removed element up to the old last one.
              idx_nxt   = clamp_pos;
              count_nxt = CW'(count_r - 1'b1);
              state_nxt = S_REM;
            end
          end
        end
      end

      S_INS: begin
        // Each cycle reads entry idx-1 and writes the entry read in the previous
        // cycle one place back. Writes always land above the read address.
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = rd_data_r;
          pend_nxt  = 1'b0;
        end
        if (idx_r > pos_r) begin
          mem_raddr     = AW'(idx_r - 1'b1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = CW'(idx_r - 1'b1);
        end else if (!pend_r) begin
          // Gap is open: the new value goes into the freed slot.
          mem_we    = 1'b1;
          mem_waddr = pos_r[AW-1:0];
          mem_wdata = value_r;
          state_nxt = S_DONE;
        end
      end

      S_REM: begin
        // The first read returns the removed element; every later read is
        // written one place forward. count_r already holds the new length,
        // which equals the index of the old last element.
        if (pend_r) begin
          pend_nxt = 1'b0;
          if (pend_first_r) begin
            removed_nxt = rd_data_r;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pend_addr_r;
            mem_wdata = rd_data_r;
          end
        end
        if (idx_r <= count_r) begin
          mem_raddr      = idx_r[AW-1:0];
          pend_nxt       = 1'b1;
          pend_first_nxt = (idx_r == pos_r);
          pend_addr_nxt  = AW'(idx_r - 1'b1);
          idx_nxt        = CW'(idx_r + 1'b1);
        end else if (!pend_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free or freeing.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_removed_nxt = removed_r;
          out_status_nxt  = status_r;
          out_length_nxt  = LEN_W'(count_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
